### rtl/core/pbpa_pkg.sv
// pbpa_pkg: shared types and codes for the paged buffer pool allocator
// no dependencies; imported by the top level and its checker
`timescale 1ns / 1ps
`default_nettype none

package pbpa_pkg;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_NOBUF   = 2'd1,
    ST_DOUBLE  = 2'd2,
    ST_CORRUPT = 2'd3
  } pbpa_status_t;

  typedef enum logic {
    OP_ALLOC = 1'b0,
    OP_FREE  = 1'b1
  } pbpa_op_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_A_CHK,
    S_W_RD,
    S_W_CHK,
    S_F_CHK,
    S_M_PV,
    S_M_NX,
    S_L_RD,
    S_L_WR,
    S_RESP
  } pbpa_state_t;

  // relink sequence when a wholly free page moves behind the top
  typedef enum logic [2:0] {
    LK_PV_NEXT    = 3'd0,
    LK_NX_PREV    = 3'd1,
    LK_AFTER      = 3'd2,
    LK_PG_PREV    = 3'd3,
    LK_PG_NEXT    = 3'd4,
    LK_TOP_NEXT   = 3'd5,
    LK_AFTER_PREV = 3'd6
  } pbpa_step_t;

endpackage

`default_nettype wire

### rtl/core/paged_buffer_pool_allocator.sv
// paged_buffer_pool_allocator: slot usage and page metadata kept in two rams
// depends on pbpa_pkg and pbpa_ram
// allocate reads the top page; when it fills, a walk over the ring looks for the next page
//   with a free slot; free rewrites the page, and may relink it when it becomes wholly free
// one request in flight; the ring walk and relink sequence over the metadata ram set the rate
// a finished result sits in the output register while the next request is taken
// reset (synchronous, rst_n low) empties the pool at once through per-page valid bits
`timescale 1ns / 1ps
`default_nettype none

module paged_buffer_pool_allocator
  import pbpa_pkg::*;
#(
  parameter int PAGES          = 4,
  parameter int SLOTS_PER_PAGE = 8
) (
  input  wire logic                                         clk,
  input  wire logic                                         rst_n,
  input  wire logic                                         in_valid,
  output logic                                              in_stall,
  input  wire logic                                         in_opcode,
  input  wire logic [$clog2(PAGES)-1:0]                     in_page_in,
  input  wire logic [$clog2(SLOTS_PER_PAGE)-1:0]            in_slot_in,
  output logic                                              out_valid,
  input  wire logic                                         out_stall,
  output logic [1:0]                                        out_status,
  output logic [$clog2(PAGES)-1:0]                          out_page_out,
  output logic [$clog2(SLOTS_PER_PAGE)-1:0]                 out_slot_out,
  output logic [$clog2(PAGES*SLOTS_PER_PAGE+1)-1:0]         out_available_out
);

  localparam int PW    = $clog2(PAGES);
  localparam int SW    = $clog2(SLOTS_PER_PAGE);
  localparam int CW    = $clog2(SLOTS_PER_PAGE + 1);
  localparam int AW    = $clog2(PAGES * SLOTS_PER_PAGE + 1);
  localparam int KW    = $clog2(PAGES + 1);
  localparam int TOTAL = PAGES * SLOTS_PER_PAGE;
  localparam int P_LO  = 0;
  localparam int N_LO  = PW;
  localparam int H_LO  = 2 * PW;
  localparam int C_LO  = 2 * PW + SW;
  localparam int MW    = 2 * PW + SW + CW;

  localparam logic [CW-1:0] FULL_CNT = CW'(SLOTS_PER_PAGE);

  function automatic logic [MW-1:0] meta_rst(input logic [PW-1:0] i);
    logic [PW-1:0] nx;
    logic [PW-1:0] pv;
    nx = ({1'b0, i} + (PW+1)'(1) == (PW+1)'(PAGES)) ? '0 : PW'(i + PW'(1));
    pv = (i == '0) ? PW'(PAGES - 1) : PW'(i - PW'(1));
    return {FULL_CNT, SW'(0), nx, pv};
  endfunction

  function automatic logic [SLOTS_PER_PAGE-1:0] slot_sel(input logic [SW-1:0] s);
    return SLOTS_PER_PAGE'(1) << s;
  endfunction

  pbpa_state_t state_r, state_nxt;
  pbpa_step_t  step_r, step_nxt;

  logic [PW-1:0]  pg_r, pg_nxt, top_r, top_nxt, walk_p_r, walk_p_nxt;
  logic [PW-1:0]  pv_r, pv_nxt, nx_r, nx_nxt, after_r, after_nxt;
  logic [SW-1:0]  sl_r, sl_nxt;
  logic [KW-1:0]  walk_k_r, walk_k_nxt;
  logic [AW-1:0]  avail_r, avail_nxt;
  logic           pvfull_r, pvfull_nxt;
  pbpa_status_t   res_status_r, res_status_nxt;
  logic [PW-1:0]  res_page_r, res_page_nxt;
  logic [SW-1:0]  res_slot_r, res_slot_nxt;

  logic           out_valid_r, out_valid_nxt;
  logic [1:0]     out_status_r, out_status_nxt;
  logic [PW-1:0]  out_page_r, out_page_nxt;
  logic [SW-1:0]  out_slot_r, out_slot_nxt;
  logic [AW-1:0]  out_avail_r, out_avail_nxt;

  logic [PAGES-1:0] row_vld_r, meta_vld_r;
  logic [PW-1:0]    meta_ra_r;
  logic             row_vq_r, meta_vq_r;

  // ram ports
  logic                      row_we, meta_we;
  logic [PW-1:0]             row_waddr, row_raddr, meta_waddr, meta_raddr;
  logic [SLOTS_PER_PAGE-1:0] row_wdata, row_rdata, row_q;
  logic [MW-1:0]             meta_wdata, meta_rdata, meta_q;

  pbpa_ram #(.W(SLOTS_PER_PAGE), .D(PAGES)) u_row_ram (
    .clk   (clk),
    .we    (row_we),
    .waddr (row_waddr),
    .wdata (row_wdata),
    .raddr (row_raddr),
    .rdata (row_rdata)
  );

  pbpa_ram #(.W(MW), .D(PAGES)) u_meta_ram (
    .clk   (clk),
    .we    (meta_we),
    .waddr (meta_waddr),
    .wdata (meta_wdata),
    .raddr (meta_raddr),
    .rdata (meta_rdata)
  );

  // never-written pages read as their reset contents
  assign row_q  = row_vq_r  ? row_rdata  : '0;
  assign meta_q = meta_vq_r ? meta_rdata : meta_rst(meta_ra_r);

  logic [CW-1:0] mq_cnt;
  logic [SW-1:0] mq_hint;
  logic [PW-1:0] mq_nxt, mq_prv;
  assign mq_cnt  = meta_q[C_LO +: CW];
  assign mq_hint = meta_q[H_LO +: SW];
  assign mq_nxt  = meta_q[N_LO +: PW];
  assign mq_prv  = meta_q[P_LO +: PW];

  // circular search for the next free slot after the taken one
  logic [SLOTS_PER_PAGE-1:0] taken_row;
  logic                      scan_found;
  logic [SW-1:0]             scan_idx;
  assign taken_row = row_q | slot_sel(mq_hint);

  always_comb begin
    int s;
    scan_found = 1'b0;
    scan_idx   = '0;
    for (int k = SLOTS_PER_PAGE - 1; k >= 1; k--) begin
      s = int'(mq_hint) + k;
      if (s >= SLOTS_PER_PAGE) s = s - SLOTS_PER_PAGE;
      if (!taken_row[s]) begin
        scan_found = 1'b1;
        scan_idx   = SW'(s);
      end
    end
  end

  // relink step target and value
  logic [PW-1:0] lk_addr, lk_val;
  logic          lk_is_next;
  always_comb begin
    lk_addr    = pg_r;
    lk_val     = pg_r;
    lk_is_next = 1'b0;
    case (step_r)
      LK_PV_NEXT:    begin lk_addr = pv_r;    lk_val = nx_r;    lk_is_next = 1'b1; end
      LK_NX_PREV:    begin lk_addr = nx_r;    lk_val = pv_r;    end
      LK_AFTER:      begin lk_addr = top_r;   lk_val = pg_r;    end
      LK_PG_PREV:    begin lk_addr = pg_r;    lk_val = top_r;   end
      LK_PG_NEXT:    begin lk_addr = pg_r;    lk_val = after_r; lk_is_next = 1'b1; end
      LK_TOP_NEXT:   begin lk_addr = top_r;   lk_val = pg_r;    lk_is_next = 1'b1; end
      LK_AFTER_PREV: begin lk_addr = after_r; lk_val = pg_r;    end
      default:       begin lk_addr = pg_r;    lk_val = pg_r;    end
    endcase
  end

  logic          hint_ok, hint_used, slot_used_f, can_load;
  logic [CW-1:0] cnt_dec, cnt_inc;
  assign hint_ok     = {1'b0, mq_hint} < (SW+1)'(SLOTS_PER_PAGE);
  assign hint_used   = |(row_q & slot_sel(mq_hint));
  assign slot_used_f = |(row_q & slot_sel(sl_r));
  assign cnt_dec     = mq_cnt - CW'(1);
  assign cnt_inc     = mq_cnt + CW'(1);
  assign can_load    = !out_valid_r || !out_stall;

  assign in_stall = (state_r != S_IDLE);

  always_comb begin
    state_nxt      = state_r;
    step_nxt       = step_r;
    pg_nxt         = pg_r;
    sl_nxt         = sl_r;
    top_nxt        = top_r;
    walk_p_nxt     = walk_p_r;
    walk_k_nxt     = walk_k_r;
    pv_nxt         = pv_r;
    nx_nxt         = nx_r;
    after_nxt      = after_r;
    avail_nxt      = avail_r;
    pvfull_nxt     = pvfull_r;
    res_status_nxt = res_status_r;
    res_page_nxt   = res_page_r;
    res_slot_nxt   = res_slot_r;
    out_valid_nxt  = out_valid_r && out_stall;
    out_status_nxt = out_status_r;
    out_page_nxt   = out_page_r;
    out_slot_nxt   = out_slot_r;
    out_avail_nxt  = out_avail_r;
    row_we         = 1'b0;
    row_waddr      = pg_r;
    row_wdata      = row_q;
    row_raddr      = pg_r;
    meta_we        = 1'b0;
    meta_waddr     = pg_r;
    meta_wdata     = meta_q;
    meta_raddr     = walk_p_r;

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          res_page_nxt = '0;
          res_slot_nxt = '0;
          if (in_opcode == OP_ALLOC) begin
            if (avail_r == '0) begin
              res_status_nxt = ST_NOBUF;
              state_nxt      = S_RESP;
            end else begin
              pg_nxt     = top_r;
              row_raddr  = top_r;
              meta_raddr = top_r;
              state_nxt  = S_A_CHK;
            end
          end else begin
            pg_nxt = in_page_in;
            sl_nxt = in_slot_in;
            if ({1'b0, in_page_in} >= (PW+1)'(PAGES) ||
                {1'b0, in_slot_in} >= (SW+1)'(SLOTS_PER_PAGE)) begin
              res_status_nxt = ST_CORRUPT;
              state_nxt      = S_RESP;
            end else begin
              row_raddr  = in_page_in;
              meta_raddr = in_page_in;
              state_nxt  = S_F_CHK;
            end
          end
        end
      end

      S_A_CHK: begin
        if (mq_cnt == '0 || !hint_ok || hint_used) begin
          res_status_nxt = ST_CORRUPT;
          state_nxt      = S_RESP;
        end else begin
          row_we       = 1'b1;
          row_wdata    = taken_row;
          avail_nxt    = avail_r - AW'(1);
          res_page_nxt = pg_r;
          res_slot_nxt = mq_hint;
          meta_we      = 1'b1;
          if (cnt_dec != '0) begin
            meta_wdata     = {cnt_dec, scan_found ? scan_idx : mq_hint, mq_nxt, mq_prv};
            res_status_nxt = scan_found ? ST_OK : ST_CORRUPT;
            state_nxt      = S_RESP;
          end else begin
            meta_wdata = {cnt_dec, mq_hint, mq_nxt, mq_prv};
            walk_p_nxt = mq_nxt;
            walk_k_nxt = '0;
            state_nxt  = S_W_RD;
          end
        end
      end

      S_W_RD: begin
        if (walk_p_r == pg_r || walk_k_r == KW'(PAGES)) begin
          res_status_nxt = (avail_r == '0) ? ST_OK : ST_CORRUPT;
          state_nxt      = S_RESP;
        end else begin
          meta_raddr = walk_p_r;
          state_nxt  = S_W_CHK;
        end
      end

      S_W_CHK: begin
        if (mq_cnt != '0) begin
          top_nxt        = walk_p_r;
          res_status_nxt = ST_OK;
          state_nxt      = S_RESP;
        end else begin
          walk_p_nxt = mq_nxt;
          walk_k_nxt = walk_k_r + KW'(1);
          state_nxt  = S_W_RD;
        end
      end

      S_F_CHK: begin
        if (!slot_used_f) begin
          res_status_nxt = ST_DOUBLE;
          state_nxt      = S_RESP;
        end else if (mq_cnt >= FULL_CNT) begin
          res_status_nxt = ST_CORRUPT;
          state_nxt      = S_RESP;
        end else begin
          row_we         = 1'b1;
          row_wdata      = row_q & ~slot_sel(sl_r);
          meta_we        = 1'b1;
          meta_wdata     = {cnt_inc, sl_r, mq_nxt, mq_prv};
          res_status_nxt = ST_OK;
          if (avail_r < AW'(TOTAL)) avail_nxt = avail_r + AW'(1);
          if (cnt_inc != FULL_CNT) begin
            state_nxt = S_RESP;
          end else begin
            pv_nxt     = mq_prv;
            nx_nxt     = mq_nxt;
            meta_raddr = mq_prv;
            state_nxt  = S_M_PV;
          end
        end
      end

      S_M_PV: begin
        pvfull_nxt = (mq_cnt == FULL_CNT);
        meta_raddr = nx_r;
        state_nxt  = S_M_NX;
      end

      S_M_NX: begin
        if (pg_r != top_r && !pvfull_r && mq_cnt != FULL_CNT) begin
          step_nxt  = LK_PV_NEXT;
          state_nxt = S_L_RD;
        end else begin
          if (mq_cnt == FULL_CNT) top_nxt = pg_r;
          state_nxt = S_RESP;
        end
      end

      S_L_RD: begin
        meta_raddr = lk_addr;
        state_nxt  = S_L_WR;
      end

      S_L_WR: begin
        if (step_r == LK_AFTER) begin
          after_nxt = mq_nxt;
        end else begin
          meta_we    = 1'b1;
          meta_waddr = lk_addr;
          meta_wdata = lk_is_next ? {mq_cnt, mq_hint, lk_val, mq_prv}
                                  : {mq_cnt, mq_hint, mq_nxt, lk_val};
        end
        if (step_r == LK_AFTER_PREV) begin
          state_nxt = S_RESP;
        end else begin
          step_nxt  = pbpa_step_t'(step_r + 3'd1);
          state_nxt = S_L_RD;
        end
      end

      S_RESP: begin
        if (can_load) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = res_status_r;
          out_page_nxt   = res_page_r;
          out_slot_nxt   = res_slot_r;
          out_avail_nxt  = avail_r;
          state_nxt      = S_IDLE;
        end
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      step_r      <= LK_PV_NEXT;
      top_r       <= '0;
      avail_r     <= AW'(TOTAL);
      out_valid_r <= 1'b0;
      row_vld_r   <= '0;
      meta_vld_r  <= '0;
      row_vq_r    <= 1'b0;
      meta_vq_r   <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      step_r      <= step_nxt;
      top_r       <= top_nxt;
      avail_r     <= avail_nxt;
      out_valid_r <= out_valid_nxt;
      if (row_we)  row_vld_r[row_waddr]   <= 1'b1;
      if (meta_we) meta_vld_r[meta_waddr] <= 1'b1;
      row_vq_r  <= row_vld_r[row_raddr] || (row_we && row_waddr == row_raddr);
      meta_vq_r <= meta_vld_r[meta_raddr] || (meta_we && meta_waddr == meta_raddr);
    end
  end

  always_ff @(posedge clk) begin
    pg_r         <= pg_nxt;
    sl_r         <= sl_nxt;
    walk_p_r     <= walk_p_nxt;
    walk_k_r     <= walk_k_nxt;
    pv_r         <= pv_nxt;
    nx_r         <= nx_nxt;
    after_r      <= after_nxt;
    pvfull_r     <= pvfull_nxt;
    res_status_r <= res_status_nxt;
    res_page_r   <= res_page_nxt;
    res_slot_r   <= res_slot_nxt;
    out_status_r <= out_status_nxt;
    out_page_r   <= out_page_nxt;
    out_slot_r   <= out_slot_nxt;
    out_avail_r  <= out_avail_nxt;
    meta_ra_r    <= meta_raddr;
  end

  assign out_valid         = out_valid_r;
  assign out_status        = out_status_r;
  assign out_page_out      = out_page_r;
  assign out_slot_out      = out_slot_r;
  assign out_available_out = out_avail_r;

endmodule

`default_nettype wire

### rtl/core/pbpa_ram.sv
// pbpa_ram: generic single write, single read ram with registered read
// write-first on a same-address read; no dependencies
`timescale 1ns / 1ps
`default_nettype none

module pbpa_ram #(
  parameter int W = 8,
  parameter int D = 4
) (
  input  wire logic                 clk,
  input  wire logic                 we,
  input  wire logic [$clog2(D)-1:0] waddr,
  input  wire logic [W-1:0]         wdata,
  input  wire logic [$clog2(D)-1:0] raddr,
  output logic      [W-1:0]         rdata
);

  logic [W-1:0] mem [D];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (we && waddr == raddr) begin
      rdata <= wdata;
    end else begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

### rtl/core/pbpa_checker.sv
// pbpa_checker: port-level checks for the paged buffer pool allocator
// depends on pbpa_pkg; bound to the top level below
`timescale 1ns / 1ps
`default_nettype none

module pbpa_checker
  import pbpa_pkg::*;
#(
  parameter int PAGES          = 4,
  parameter int SLOTS_PER_PAGE = 8
) (
  input wire logic                                     clk,
  input wire logic                                     rst_n,
  input wire logic                                     in_valid,
  input wire logic                                     in_stall,
  input wire logic                                     out_valid,
  input wire logic                                     out_stall,
  input wire logic [1:0]                               out_status,
  input wire logic [$clog2(PAGES)-1:0]                 out_page_out,
  input wire logic [$clog2(SLOTS_PER_PAGE)-1:0]        out_slot_out,
  input wire logic [$clog2(PAGES*SLOTS_PER_PAGE+1)-1:0] out_available_out
);

  localparam int AW = $clog2(PAGES * SLOTS_PER_PAGE + 1);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_status) &&
      $stable(out_available_out))
    else $error("stalled result beat changed");

  a_nobuf_empty: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == ST_NOBUF |-> out_available_out == '0)
    else $error("no buffer reported with buffers left");

  a_double_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == ST_DOUBLE |-> out_page_out == '0 && out_slot_out == '0)
    else $error("double free carries a buffer");

  a_count_cap: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_available_out <= AW'(PAGES * SLOTS_PER_PAGE))
    else $error("available count above pool size");

  // one request in flight: an accepted beat stalls the input next cycle
  a_in_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("second request taken while one is in flight");

endmodule

bind paged_buffer_pool_allocator pbpa_checker #(
  .PAGES          (PAGES),
  .SLOTS_PER_PAGE (SLOTS_PER_PAGE)
) u_pbpa_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .in_valid          (in_valid),
  .in_stall          (in_stall),
  .out_valid         (out_valid),
  .out_stall         (out_stall),
  .out_status        (out_status),
  .out_page_out      (out_page_out),
  .out_slot_out      (out_slot_out),
  .out_available_out (out_available_out)
);

`default_nettype wire

### tb/paged_buffer_pool_allocator_test.sv
// paged_buffer_pool_allocator_test: self-checking bench for the page pool allocator
// drives allocate/free beats, predicts each response with a local pool model
// depends on pbpa_pkg and the allocator rtl
`timescale 1ns / 1ps

module paged_buffer_pool_allocator_test;
  import pbpa_pkg::*;

  localparam int PG = 4;
  localparam int SL = 8;
  localparam int TOTAL = PG * SL;

  typedef struct packed {
    logic [1:0] status;
    logic [1:0] page;
    logic [2:0] slot;
    logic [5:0] avail;
  } resp_t;

  logic clk = 0;
  logic rst_n = 0;
  logic in_valid = 0;
  logic in_opcode = 0;
  logic [1:0] in_page_in = 0;
  logic [2:0] in_slot_in = 0;
  logic out_stall = 0;
  wire in_stall, out_valid;
  wire [1:0] out_status, out_page_out;
  wire [2:0] out_slot_out;
  wire [5:0] out_available_out;

  paged_buffer_pool_allocator #(.PAGES(PG), .SLOTS_PER_PAGE(SL)) uut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_opcode(in_opcode),
    .in_page_in(in_page_in), .in_slot_in(in_slot_in),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_status(out_status), .out_page_out(out_page_out),
    .out_slot_out(out_slot_out), .out_available_out(out_available_out)
  );

  always #4 clk = ~clk;

  // pool shadow
  bit       used [TOTAL];
  int       pfree [PG];
  int       phint [PG];
  int       nxt [PG];
  int       prv [PG];
  int       top;
  int       avail;

  resp_t    pending_resp [$];
  int       mismatches = 0;
  int       beats_sent = 0;
  int       beats_seen = 0;
  int       n_nobuf = 0, n_double = 0, n_corrupt = 0;
  int       out_wait = 0;

  function automatic void pool_reset();
    for (int i = 0; i < TOTAL; i++) used[i] = 0;
    for (int i = 0; i < PG; i++) begin
      pfree[i] = SL;
      phint[i] = 0;
      nxt[i] = (i + 1) % PG;
      prv[i] = (i + PG - 1) % PG;
    end
    top = 0;
    avail = TOTAL;
  endfunction

  function automatic void relink_full_page(int p);
    int pv, nx, after;
    pv = prv[p];
    nx = nxt[p];
    if (p != top && pfree[pv] != SL && pfree[nx] != SL) begin
      nxt[pv] = nx;
      prv[nx] = pv;
      after = nxt[top];
      prv[p] = top;
      nxt[p] = after;
      nxt[top] = p;
      prv[after] = p;
    end else if (pfree[nx] == SL) begin
      top = p;
    end
  endfunction

  function automatic resp_t pool_step(logic op, int p, int s);
    resp_t r;
    int pg, sl, q, k;
    bit found;
    r = '0;
    if (op == OP_ALLOC) begin
      pg = top;
      sl = phint[pg];
      if (avail == 0) r.status = ST_NOBUF;
      else if (pfree[pg] == 0 || used[pg*SL+sl]) r.status = ST_CORRUPT;
      else begin
        used[pg*SL+sl] = 1;
        avail--;
        pfree[pg]--;
        r.page = pg;
        r.slot = sl;
        found = 0;
        if (pfree[pg] != 0) begin
          q = sl;
          for (k = 0; k < SL - 1 && !found; k++) begin
            q = (q + 1) % SL;
            if (!used[pg*SL+q]) begin
              phint[pg] = q;
              found = 1;
            end
          end
          r.status = found ? ST_OK : ST_CORRUPT;
        end else begin
          q = nxt[pg];
          for (k = 0; k < PG && q != pg && !found; k++) begin
            if (pfree[q] != 0) begin
              top = q;
              found = 1;
            end else q = nxt[q];
          end
          r.status = (found || avail == 0) ? ST_OK : ST_CORRUPT;
        end
      end
    end else begin
      if (!used[p*SL+s]) r.status = ST_DOUBLE;
      else if (pfree[p] >= SL) r.status = ST_CORRUPT;
      else begin
        used[p*SL+s] = 0;
        phint[p] = s;
        pfree[p]++;
        if (pfree[p] == SL) relink_full_page(p);
        if (avail < TOTAL) avail++;
        r.status = ST_OK;
      end
    end
    r.avail = avail;
    return r;
  endfunction

  // valid stays high into the next beat when no idle cycles are drawn
  task automatic send_beat(logic op, int p, int s);
    int gap;
    gap = $urandom_range(0, 4);
    if (gap != 0) begin
      in_valid <= 0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1;
    in_opcode <= op;
    in_page_in <= 2'(p);
    in_slot_in <= 3'(s);
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pending_resp.push_back(pool_step(op, p, s));
    beats_sent++;
    @(negedge clk);
  endtask

  // pick a used slot when there is one, else anything
  task automatic free_used_slot();
    int idx, tries;
    idx = $urandom_range(0, TOTAL - 1);
    for (tries = 0; tries < TOTAL && !used[idx]; tries++) idx = (idx + 1) % TOTAL;
    send_beat(OP_FREE, idx / SL, idx % SL);
  endtask

  task automatic drain();
    in_valid <= 0;
    @(negedge clk);
    while (pending_resp.size() != 0) @(negedge clk);
  endtask

  // result side applies random back-pressure to each result beat
  always @(negedge clk) begin
    if (out_valid && out_wait > 0) begin
      out_stall <= 1'b1;
      out_wait = out_wait - 1;
    end else begin
      out_stall <= 1'b0;
      if (out_valid) out_wait = $urandom_range(0, 4);
    end
  end

  always @(posedge clk) begin
    resp_t want;
    if (rst_n && out_valid && !out_stall) begin
      beats_seen++;
      if (pending_resp.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected response status=%0d", out_status);
      end else begin
        want = pending_resp.pop_front();
        if (want.status == ST_NOBUF) n_nobuf++;
        if (want.status == ST_DOUBLE) n_double++;
        if (want.status == ST_CORRUPT) n_corrupt++;
        if (out_status !== want.status || out_page_out !== want.page ||
            out_slot_out !== want.slot || out_available_out !== want.avail) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: exp st=%0d pg=%0d sl=%0d av=%0d got st=%0d pg=%0d sl=%0d av=%0d",
                     want.status, want.page, want.slot, want.avail,
                     out_status, out_page_out, out_slot_out, out_available_out);
        end
      end
    end
  end

  task automatic test_fill_and_empty();
    for (int i = 0; i < TOTAL + 2; i++) send_beat(OP_ALLOC, 0, 0);
    send_beat(OP_FREE, 3, 7);
    send_beat(OP_FREE, 3, 7);
    send_beat(OP_ALLOC, 0, 0);
    drain();
  endtask

  task automatic test_double_and_full_page();
    for (int i = 0; i < TOTAL; i++) send_beat(OP_FREE, i / SL, i % SL);
    send_beat(OP_FREE, 0, 0);
    send_beat(OP_FREE, 2, 5);
    drain();
  endtask

  task automatic test_random_mix(int count);
    int mode;
    for (int i = 0; i < count; i++) begin
      mode = $urandom_range(0, 9);
      if (mode < 5) send_beat(OP_ALLOC, $urandom_range(0, 3), $urandom_range(0, 7));
      else if (mode < 9) free_used_slot();
      else send_beat(OP_FREE, $urandom_range(0, 3), $urandom_range(0, 7));
      // pause for the pipeline to empty now and then
      if ($urandom_range(0, 199) == 0) drain();
    end
    drain();
  endtask

  task automatic test_bursty_pages(int rounds);
    int n_alloc;
    // allocate 16 to 34 buffers then free 30 slots, used ones when any remain, so pages empty and are relinked
    for (int r = 0; r < rounds; r++) begin
      n_alloc = $urandom_range(16, 34);
      for (int i = 0; i < n_alloc; i++) send_beat(OP_ALLOC, 0, 0);
      for (int i = 0; i < 30; i++) free_used_slot();
    end
    drain();
  endtask

  initial begin
    pool_reset();
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1;
    test_fill_and_empty();
    test_double_and_full_page();
    test_random_mix(920);
    test_bursty_pages(12);
    repeat (40) @(posedge clk);
    $display("covered %0d requests: %0d no-buffer, %0d double free, %0d corrupt",
             beats_sent, n_nobuf, n_double, n_corrupt);
    if (mismatches == 0 && pending_resp.size() == 0) $display("status: pass");
    else $display("status: fail");
    $finish;
  end

  initial begin
    #2000000;
    $display("status: fail");
    $finish;
  end

endmodule

### paged_buffer_pool_allocator.f
rtl/core/pbpa_pkg.sv
rtl/core/pbpa_ram.sv
rtl/core/paged_buffer_pool_allocator.sv
rtl/core/pbpa_checker.sv
tb/paged_buffer_pool_allocator_test.sv
